[hdl/chm_pkg.sv]
// ---------------------------------------------------------------------------
// chm_pkg: shared types and constants for the coverage histogram mode unit
// Holds the result field widths and the control groups passed between
// the coverage summing stage, the histogram update stage and the top level.
// ---------------------------------------------------------------------------
package chm_pkg;

    // Fixed widths of the result fields
    localparam int unsigned MODE_BITS  = 10;
    localparam int unsigned SITES_BITS = 32;

    // Number of strand-specific base counts per site
    localparam int unsigned NUM_COUNTS = 8;

    // Control for one site moving from the summing stage to the update stage
    typedef struct packed {
        logic valid;
        logic last;
        logic clamp;
    } chm_site_ctrl_t;

    // Status from the update stage back to the top level
    typedef struct packed {
        logic clearing;
        logic result_valid;
    } chm_upd_status_t;

endpackage

[hdl/chm_cov_sum.sv]
// ---------------------------------------------------------------------------
// chm_cov_sum: coverage summing stage
// Registers the sum of the eight base counts of an accepted site and clamps
// it to the top histogram bin, flagging the clamp.
// ---------------------------------------------------------------------------
module chm_cov_sum
    import chm_pkg::*;
#(
    parameter int unsigned BIN_COUNT  = 1024,
    parameter int unsigned COUNT_BITS = 12
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          accept,
    input  logic [COUNT_BITS-1:0]         counts [NUM_COUNTS],
    input  logic                          last_site,
    output chm_site_ctrl_t                ctrl,
    output logic [$clog2(BIN_COUNT)-1:0]  bin
);

    localparam int unsigned BIN_BITS = $clog2(BIN_COUNT);
    localparam int unsigned SUM_BITS = COUNT_BITS + 3;
    localparam int unsigned CMP_BITS = (SUM_BITS > BIN_BITS) ? SUM_BITS : BIN_BITS;
    localparam logic [CMP_BITS-1:0] TOP_BIN_EXT = CMP_BITS'(BIN_COUNT - 1);
    localparam logic [BIN_BITS-1:0] TOP_BIN     = BIN_BITS'(BIN_COUNT - 1);

    logic                valid_reg;
    logic                last_reg;
    logic [SUM_BITS-1:0] sum_reg;
    logic [SUM_BITS-1:0] sum_next;
    logic [CMP_BITS-1:0] sum_ext;
    logic                over;

    // Add the eight counts of the incoming request
    always_comb
    begin
        sum_next = '0;
        for (int i = 0; i < NUM_COUNTS; i++)
        begin
            sum_next = sum_next + SUM_BITS'(counts[i]);
        end
    end

    // Hold the valid flag of the stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= accept;
        end
    end

    // Capture the payload of an accepted request
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sum_reg  <= sum_next;
            last_reg <= last_site;
        end
    end

    // Clamp the coverage into the top bin
    assign sum_ext = CMP_BITS'(sum_reg);
    assign over    = (sum_ext > TOP_BIN_EXT);
    assign bin     = over ? TOP_BIN : sum_ext[BIN_BITS-1:0];

    assign ctrl.valid = valid_reg;
    assign ctrl.last  = last_reg;
    assign ctrl.clamp = over;

endmodule

[hdl/chm_bin_update.sv]
// ---------------------------------------------------------------------------
// chm_bin_update: histogram memory and running mode tracker
// Reads the bin of a site, increments it with saturation and writes it back,
// forwarding the previous write when the same bin follows directly. Keeps
// the best bin and the clamp flag, reports the result on the last site and
// then sweeps the memory back to zero.
// ---------------------------------------------------------------------------
module chm_bin_update
    import chm_pkg::*;
#(
    parameter int unsigned BIN_COUNT = 1024
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  chm_site_ctrl_t                site_ctrl,
    input  logic [$clog2(BIN_COUNT)-1:0]  site_bin,
    output chm_upd_status_t               status,
    output logic [MODE_BITS-1:0]          result_coverage,
    output logic [SITES_BITS-1:0]         result_sites,
    output logic                          result_clamp
);

    localparam int unsigned BIN_BITS = $clog2(BIN_COUNT);
    localparam int unsigned EXT_BITS = (BIN_BITS > MODE_BITS) ? BIN_BITS : MODE_BITS;
    localparam logic [BIN_BITS-1:0] LAST_ADDR = BIN_BITS'(BIN_COUNT - 1);

    // Histogram store
    logic [SITES_BITS-1:0] hist_mem [BIN_COUNT];

    logic                  s2_valid_reg;
    logic                  s2_last_reg;
    logic                  s2_clamp_reg;
    logic [BIN_BITS-1:0]   s2_bin_reg;
    logic [SITES_BITS-1:0] rdata_reg;
    logic                  fwd_valid_reg;
    logic [BIN_BITS-1:0]   fwd_bin_reg;
    logic [SITES_BITS-1:0] fwd_count_reg;
    logic [BIN_BITS-1:0]   best_bin_reg;
    logic [SITES_BITS-1:0] best_count_reg;
    logic                  clamp_flag_reg;
    logic                  clearing_reg;
    logic [BIN_BITS-1:0]   sweep_addr_reg;

    logic [SITES_BITS-1:0] old_count;
    logic [SITES_BITS-1:0] new_count;
    logic                  take;
    logic [BIN_BITS-1:0]   best_bin_next;
    logic [SITES_BITS-1:0] best_count_next;
    logic                  clamp_flag_next;
    logic                  mem_we;
    logic [BIN_BITS-1:0]   mem_waddr;
    logic [SITES_BITS-1:0] mem_wdata;
    logic [EXT_BITS-1:0]   best_bin_ext;

    // Pick the freshest count: forward the write of the previous cycle
    always_comb
    begin
        if (fwd_valid_reg && (fwd_bin_reg == s2_bin_reg))
        begin
            old_count = fwd_count_reg;
        end
        else
        begin
            old_count = rdata_reg;
        end
    end

    // Increment with saturation and update the running best bin
    assign new_count = (old_count == '1) ? old_count : old_count + SITES_BITS'(1);
    assign take = (new_count > best_count_reg) ||
                  ((new_count == best_count_reg) && (s2_bin_reg < best_bin_reg));
    assign best_bin_next   = take ? s2_bin_reg : best_bin_reg;
    assign best_count_next = take ? new_count  : best_count_reg;
    assign clamp_flag_next = clamp_flag_reg | s2_clamp_reg;

    // Share the write port between the update and the clearing sweep
    assign mem_we    = clearing_reg || s2_valid_reg;
    assign mem_waddr = clearing_reg ? sweep_addr_reg : s2_bin_reg;
    assign mem_wdata = clearing_reg ? '0 : new_count;

    // Memory: one write port, one registered read port (old data on collision)
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            hist_mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= hist_mem[site_bin];
    end

    // Advance the payload of the update stage and the forwarding register
    always_ff @(posedge clk)
    begin
        s2_last_reg   <= site_ctrl.last;
        s2_clamp_reg  <= site_ctrl.clamp;
        s2_bin_reg    <= site_bin;
        fwd_bin_reg   <= s2_bin_reg;
        fwd_count_reg <= new_count;
    end

    // Control state: valid flags, best bin, clamp flag and clearing sweep
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg   <= 1'b0;
            fwd_valid_reg  <= 1'b0;
            best_bin_reg   <= '0;
            best_count_reg <= '0;
            clamp_flag_reg <= 1'b0;
            clearing_reg   <= 1'b1;
            sweep_addr_reg <= '0;
        end
        else
        begin
            s2_valid_reg  <= site_ctrl.valid;
            fwd_valid_reg <= s2_valid_reg && !s2_last_reg;
            if (clearing_reg)
            begin
                sweep_addr_reg <= sweep_addr_reg + BIN_BITS'(1);
                if (sweep_addr_reg == LAST_ADDR)
                begin
                    clearing_reg <= 1'b0;
                end
            end
            if (s2_valid_reg)
            begin
                if (s2_last_reg)
                begin
                    best_bin_reg   <= '0;
                    best_count_reg <= '0;
                    clamp_flag_reg <= 1'b0;
                    clearing_reg   <= 1'b1;
                    sweep_addr_reg <= '0;
                end
                else
                begin
                    best_bin_reg   <= best_bin_next;
                    best_count_reg <= best_count_next;
                    clamp_flag_reg <= clamp_flag_next;
                end
            end
        end
    end

    // Present the result of the last site
    assign best_bin_ext    = EXT_BITS'(best_bin_next);
    assign result_coverage = best_bin_ext[MODE_BITS-1:0];
    assign result_sites    = best_count_next;
    assign result_clamp    = clamp_flag_next;

    assign status.clearing     = clearing_reg;
    assign status.result_valid = s2_valid_reg && s2_last_reg;

    // No site reaches the update stage during the clearing sweep
    assert property (@(posedge clk) disable iff (!rst_n)
        clearing_reg |-> !s2_valid_reg)
        else $error("site in update stage during clearing sweep");

    // The last site starts the sweep and drops the running best count
    assert property (@(posedge clk) disable iff (!rst_n)
        (s2_valid_reg && s2_last_reg) |=> (clearing_reg && (best_count_reg == '0)))
        else $error("last site did not clear the tracker");

    // A counted site always leaves a non-zero best count
    assert property (@(posedge clk) disable iff (!rst_n)
        (s2_valid_reg && !s2_last_reg) |=> (best_count_reg != '0))
        else $error("best count zero after a counted site");

    // Forwarding is never armed while the memory is being cleared
    assert property (@(posedge clk) disable iff (!rst_n)
        clearing_reg |-> !fwd_valid_reg)
        else $error("forwarding armed during clearing sweep");

endmodule

[hdl/coverage_histogram_mode_unit.sv]
// ---------------------------------------------------------------------------
// coverage_histogram_mode_unit: modal coverage of a stream of genome sites
// Takes one site per request on the site channel (site_valid/site_stall),
// sums its eight strand-specific base counts into a coverage, counts that
// coverage in a histogram memory (top bin catches and flags overflow) and
// tracks the most frequent coverage, smallest on ties. A site with last_site
// set is counted and then yields one request on the mode channel
// (mode_valid/mode_stall): mode_coverage, mode_sites and clamp_seen.
// Throughput: one site per cycle while site_stall is low; a repeat of the same
// bin is forwarded past the registered memory read. A last site passes the sum
// register and the update stage register before mode_valid rises.
// After reset and after each last site the histogram memory is swept to zero,
// one bin per cycle over all BIN_COUNT bins (1024 by default); site_stall
// stays high from the acceptance of a last site until the sweep ends.
// The result waits in an output register while mode_stall is high; sites
// keep flowing meanwhile, but a further last site is held off until the
// waiting result has been taken.
// ---------------------------------------------------------------------------
module coverage_histogram_mode_unit
    import chm_pkg::*;
#(
    parameter int unsigned BIN_COUNT  = 1024,
    parameter int unsigned COUNT_BITS = 12
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    site_valid,
    output logic                    site_stall,
    input  logic [COUNT_BITS-1:0]   count_a_fwd,
    input  logic [COUNT_BITS-1:0]   count_g_fwd,
    input  logic [COUNT_BITS-1:0]   count_c_fwd,
    input  logic [COUNT_BITS-1:0]   count_t_fwd,
    input  logic [COUNT_BITS-1:0]   count_a_rev,
    input  logic [COUNT_BITS-1:0]   count_g_rev,
    input  logic [COUNT_BITS-1:0]   count_c_rev,
    input  logic [COUNT_BITS-1:0]   count_t_rev,
    input  logic                    last_site,
    output logic                    mode_valid,
    input  logic                    mode_stall,
    output logic [MODE_BITS-1:0]    mode_coverage,
    output logic [SITES_BITS-1:0]   mode_sites,
    output logic                    clamp_seen
);

    localparam int unsigned BIN_BITS = $clog2(BIN_COUNT);

    logic [COUNT_BITS-1:0] counts [NUM_COUNTS];
    logic                  accept;
    chm_site_ctrl_t        site_ctrl;
    logic [BIN_BITS-1:0]   site_bin;
    chm_upd_status_t       status;
    logic [MODE_BITS-1:0]  result_coverage;
    logic [SITES_BITS-1:0] result_sites;
    logic                  result_clamp;

    logic                  pending_reg;
    logic                  mode_valid_reg;
    logic [MODE_BITS-1:0]  mode_coverage_reg;
    logic [SITES_BITS-1:0] mode_sites_reg;
    logic                  clamp_seen_reg;

    assign counts[0] = count_a_fwd;
    assign counts[1] = count_g_fwd;
    assign counts[2] = count_c_fwd;
    assign counts[3] = count_t_fwd;
    assign counts[4] = count_a_rev;
    assign counts[5] = count_g_rev;
    assign counts[6] = count_c_rev;
    assign counts[7] = count_t_rev;

    // Hold off sites during a last site's flight and the sweep, and a new
    // last site while a result still waits
    assign site_stall = pending_reg || status.clearing || (last_site && mode_valid_reg);
    assign accept     = site_valid && !site_stall;

    chm_cov_sum #(
        .BIN_COUNT  (BIN_COUNT),
        .COUNT_BITS (COUNT_BITS)
    ) u_cov_sum (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .counts    (counts),
        .last_site (last_site),
        .ctrl      (site_ctrl),
        .bin       (site_bin)
    );

    chm_bin_update #(
        .BIN_COUNT (BIN_COUNT)
    ) u_bin_update (
        .clk             (clk),
        .rst_n           (rst_n),
        .site_ctrl       (site_ctrl),
        .site_bin        (site_bin),
        .status          (status),
        .result_coverage (result_coverage),
        .result_sites    (result_sites),
        .result_clamp    (result_clamp)
    );

    // Track a last site in flight and the output request valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg    <= 1'b0;
            mode_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept && last_site)
            begin
                pending_reg <= 1'b1;
            end
            else if (status.clearing)
            begin
                pending_reg <= 1'b0;
            end
            if (status.result_valid)
            begin
                mode_valid_reg <= 1'b1;
            end
            else if (!mode_stall)
            begin
                mode_valid_reg <= 1'b0;
            end
        end
    end

    // Load the result into the output register
    always_ff @(posedge clk)
    begin
        if (status.result_valid)
        begin
            mode_coverage_reg <= result_coverage;
            mode_sites_reg    <= result_sites;
            clamp_seen_reg    <= result_clamp;
        end
    end

    assign mode_valid    = mode_valid_reg;
    assign mode_coverage = mode_coverage_reg;
    assign mode_sites    = mode_sites_reg;
    assign clamp_seen    = clamp_seen_reg;

endmodule

[tb/coverage_histogram_mode_unit_test.sv]
// ---------------------------------------------------------------------------
// coverage_histogram_mode_unit_test: self-checking bench for the modal
// coverage unit
// Streams genome sites into the unit in data sets closed by a last site.
// A software histogram follows every accepted request and predicts the
// modal coverage, its site count and the clamp flag, which are compared
// with each request taken from the mode channel. Both channels idle at
// random, with one stretch of full throughput.
// ---------------------------------------------------------------------------

localparam int unsigned SITE_COUNT_BITS = 12;

typedef logic [chm_pkg::NUM_COUNTS-1:0][SITE_COUNT_BITS-1:0] site_counts_t;

typedef struct {
    logic [chm_pkg::MODE_BITS-1:0]  mode_coverage;
    logic [chm_pkg::SITES_BITS-1:0] mode_sites;
    logic                           clamp_seen;
} mode_result_t;

class mode_scoreboard;
    localparam int unsigned BINS    = 1024;
    localparam int unsigned TOP_BIN = BINS - 1;

    bit [31:0]    bin_tally [BINS];
    int unsigned  lead_bin;
    bit [31:0]    lead_tally;
    bit           clamp_sticky;
    mode_result_t pending_modes [$];
    int unsigned  errors;

    function new();
        errors = 0;
        clear_histogram();
    endfunction

    function void clear_histogram();
        foreach (bin_tally[i])
            bin_tally[i] = '0;
        lead_bin     = 0;
        lead_tally   = '0;
        clamp_sticky = 1'b0;
    endfunction

    // Count one accepted site; a last site closes the data set
    function void note_site(site_counts_t counts, bit last);
        int unsigned  coverage;
        int unsigned  bin_idx;
        bit [31:0]    tally;
        mode_result_t res;
        coverage = 0;
        for (int i = 0; i < chm_pkg::NUM_COUNTS; i++)
            coverage += counts[i];
        // clamp into the top bin and remember it
        if (coverage > TOP_BIN)
        begin
            bin_idx      = TOP_BIN;
            clamp_sticky = 1'b1;
        end
        else
        begin
            bin_idx = coverage;
        end
        // saturating increment
        tally = bin_tally[bin_idx];
        if (tally != 32'hFFFF_FFFF)
            tally++;
        bin_tally[bin_idx] = tally;
        // leader: highest tally, smallest coverage on a tie
        if (tally > lead_tally || (tally == lead_tally && bin_idx < lead_bin))
        begin
            lead_bin   = bin_idx;
            lead_tally = tally;
        end
        if (last)
        begin
            res.mode_coverage = chm_pkg::MODE_BITS'(lead_bin);
            res.mode_sites    = lead_tally;
            res.clamp_seen    = clamp_sticky;
            pending_modes.insert(pending_modes.size(), res);
            clear_histogram();
        end
    endfunction

    // Compare a taken result with the oldest prediction
    function void check_mode(realtime stamp, logic [chm_pkg::MODE_BITS-1:0] cov,
                             logic [chm_pkg::SITES_BITS-1:0] sites, logic clamp);
        mode_result_t want;
        if (pending_modes.size() == 0)
        begin
            $display("%0t: unexpected result, coverage %0d sites %0d clamp %0b",
                     stamp, cov, sites, clamp);
            errors++;
            return;
        end
        want = pending_modes.pop_front();
        if (cov !== want.mode_coverage)
        begin
            $display("%0t: mode_coverage mismatch, expected %0d, actual %0d",
                     stamp, want.mode_coverage, cov);
            errors++;
        end
        if (sites !== want.mode_sites)
        begin
            $display("%0t: mode_sites mismatch, expected %0d, actual %0d",
                     stamp, want.mode_sites, sites);
            errors++;
        end
        if (clamp !== want.clamp_seen)
        begin
            $display("%0t: clamp_seen mismatch, expected %0b, actual %0b",
                     stamp, want.clamp_seen, clamp);
            errors++;
        end
    endfunction
endclass

module coverage_histogram_mode_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import chm_pkg::*;

    localparam int unsigned SITE_TARGET = 700;
    localparam int unsigned QUIET_LIMIT = 10000;
    localparam int unsigned COUNT_MAX   = (1 << SITE_COUNT_BITS) - 1;
    localparam int unsigned COVER_MAX   = NUM_COUNTS * COUNT_MAX;

    logic                       clk         = 1'b0;
    logic                       rst_n       = 1'b0;
    logic                       site_valid  = 1'b0;
    logic                       site_stall;
    logic [SITE_COUNT_BITS-1:0] count_a_fwd = '0;
    logic [SITE_COUNT_BITS-1:0] count_g_fwd = '0;
    logic [SITE_COUNT_BITS-1:0] count_c_fwd = '0;
    logic [SITE_COUNT_BITS-1:0] count_t_fwd = '0;
    logic [SITE_COUNT_BITS-1:0] count_a_rev = '0;
    logic [SITE_COUNT_BITS-1:0] count_g_rev = '0;
    logic [SITE_COUNT_BITS-1:0] count_c_rev = '0;
    logic [SITE_COUNT_BITS-1:0] count_t_rev = '0;
    logic                       last_site   = 1'b0;
    logic                       mode_valid;
    logic                       mode_stall  = 1'b0;
    logic [MODE_BITS-1:0]       mode_coverage;
    logic [SITES_BITS-1:0]      mode_sites;
    logic                       clamp_seen;

    mode_scoreboard          board;
    bit                      gaps_on     = 1'b1;
    int unsigned             sites_sent  = 0;
    int unsigned             quiet_cycles = 0;

    coverage_histogram_mode_unit #(
        .BIN_COUNT  (1024),
        .COUNT_BITS (SITE_COUNT_BITS)
    ) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .site_valid    (site_valid),
        .site_stall    (site_stall),
        .count_a_fwd   (count_a_fwd),
        .count_g_fwd   (count_g_fwd),
        .count_c_fwd   (count_c_fwd),
        .count_t_fwd   (count_t_fwd),
        .count_a_rev   (count_a_rev),
        .count_g_rev   (count_g_rev),
        .count_c_rev   (count_c_rev),
        .count_t_rev   (count_t_rev),
        .last_site     (last_site),
        .mode_valid    (mode_valid),
        .mode_stall    (mode_stall),
        .mode_coverage (mode_coverage),
        .mode_sites    (mode_sites),
        .clamp_seen    (clamp_seen)
    );

    always #5 clk = ~clk;

    // Stall the mode channel at random while gaps are enabled
    always @(negedge clk)
    begin
        mode_stall <= gaps_on && ($urandom_range(99) < 35);
    end

    // Observe accepted requests on both channels and guard against a hang
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (site_valid && !site_stall)
                board.note_site({count_t_rev, count_c_rev, count_g_rev, count_a_rev,
                                 count_t_fwd, count_c_fwd, count_g_fwd, count_a_fwd},
                                last_site);
            if (mode_valid && !mode_stall)
                board.check_mode($realtime, mode_coverage, mode_sites, clamp_seen);
            if ((site_valid && !site_stall) || (mode_valid && !mode_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("%0t: no request accepted for %0d cycles", $realtime, QUIET_LIMIT);
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // Spread a coverage over the eight counts, each within its width
    function automatic site_counts_t split_coverage(int unsigned coverage);
        site_counts_t counts;
        int unsigned  rest;
        int unsigned  room;
        int unsigned  lo;
        int unsigned  hi;
        rest = coverage;
        for (int i = 0; i < NUM_COUNTS; i++)
        begin
            room      = COUNT_MAX * (NUM_COUNTS - 1 - i);
            lo        = (rest > room) ? rest - room : 0;
            hi        = (rest > COUNT_MAX) ? COUNT_MAX : rest;
            counts[i] = SITE_COUNT_BITS'($urandom_range(hi, lo));
            rest     -= counts[i];
        end
        return counts;
    endfunction

    // Offer one site, with a random gap first; called and left at a falling edge
    task automatic send_site(site_counts_t counts, bit last);
        while (gaps_on && $urandom_range(99) < 35)
        begin
            site_valid <= 1'b0;
            @(negedge clk);
        end
        site_valid  <= 1'b1;
        count_a_fwd <= counts[0];
        count_g_fwd <= counts[1];
        count_c_fwd <= counts[2];
        count_t_fwd <= counts[3];
        count_a_rev <= counts[4];
        count_g_rev <= counts[5];
        count_c_rev <= counts[6];
        count_t_rev <= counts[7];
        last_site   <= last;
        @(posedge clk);
        while (site_stall)
            @(posedge clk);
        sites_sent++;
        @(negedge clk);
    endtask

    task automatic send_coverage(int unsigned coverage, bit last);
        send_site(split_coverage(coverage), last);
    endtask

    // Hold the site channel until every predicted result has been taken
    task automatic wait_drained();
        site_valid <= 1'b0;
        @(negedge clk);
        while (board.pending_modes.size() != 0)
            @(negedge clk);
    endtask

    initial
    begin : stimulus
        int unsigned  set_len;
        int unsigned  pool_size;
        int unsigned  pool [4];
        int unsigned  pick;
        bit           mid_pause_done;
        site_counts_t counts;

        board          = new();
        mid_pause_done = 1'b0;

        // hold reset, then release it at a falling edge
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // single-site sets: empty coverage, all counts full, top bin exact, just over the top bin
        send_coverage(0, 1'b1);
        send_site({NUM_COUNTS{SITE_COUNT_BITS'(COUNT_MAX)}}, 1'b1);
        send_coverage(1023, 1'b1);
        send_coverage(1024, 1'b1);
        // three-way tie goes to the smallest coverage
        send_coverage(7, 1'b0);
        send_coverage(3, 1'b0);
        send_coverage(5, 1'b1);
        // a smaller coverage catching up with the leader takes over
        send_coverage(9, 1'b0);
        send_coverage(9, 1'b0);
        send_coverage(4, 1'b0);
        send_coverage(4, 1'b1);
        // exact top bin and clamped sites share one bin
        send_coverage(1023, 1'b0);
        send_coverage(5000, 1'b0);
        send_coverage(2, 1'b1);
        // alternating bit patterns in every count
        send_site({NUM_COUNTS{12'hAAA}}, 1'b0);
        send_site({NUM_COUNTS{12'h555}}, 1'b1);

        wait_drained();

        // random data sets drawn from a small pool of coverages
        while (sites_sent < SITE_TARGET)
        begin
            gaps_on = !(sites_sent >= 300 && sites_sent < 420);
            if (!mid_pause_done && sites_sent >= 500)
            begin
                wait_drained();
                mid_pause_done = 1'b1;
            end
            pick = $urandom_range(99);
            if (pick < 10)
                set_len = 1;
            else if (pick < 85)
                set_len = $urandom_range(12, 2);
            else
                set_len = $urandom_range(40, 13);
            pool_size = $urandom_range(4, 1);
            for (int p = 0; p < pool_size; p++)
            begin
                pick = $urandom_range(99);
                if (pick < 70)
                    pool[p] = $urandom_range(1023, 0);
                else if (pick < 80)
                    pool[p] = 1023;
                else if (pick < 90)
                    pool[p] = $urandom_range(COVER_MAX, 1024);
                else
                    pool[p] = $urandom_range(15, 0);
            end
            for (int k = 0; k < set_len; k++)
            begin
                if ($urandom_range(99) < 10)
                begin
                    // noise: every count fully random
                    for (int i = 0; i < NUM_COUNTS; i++)
                        counts[i] = SITE_COUNT_BITS'($urandom_range(COUNT_MAX, 0));
                end
                else
                begin
                    counts = split_coverage(pool[$urandom_range(pool_size - 1, 0)]);
                end
                send_site(counts, k == set_len - 1);
            end
        end

        // drain, allow the output latency, then report
        wait_drained();
        repeat (10) @(posedge clk);
        if (board.errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
